// ===== design/nearest_point_matcher_core_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the nearest point matcher
// Shared concurrent assertion forms, clocked on the rising edge.
// ---------------------------------------------------------------------------
`ifndef NEAREST_POINT_MATCHER_CORE_DEFINES_SVH
`define NEAREST_POINT_MATCHER_CORE_DEFINES_SVH

// assertion that is muted while reset is high
`define NPM_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// assertion that is checked through reset as well
`define NPM_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) \
      else $error(msg);

`endif

// ===== design/npm_pkg.sv =====
// ---------------------------------------------------------------------------
// npm_pkg
// Types, widths and codes shared by the nearest point matcher modules.
// ---------------------------------------------------------------------------
`default_nettype none

package npm_pkg;

   localparam int MAX_POINTS_DEF = 64;

   localparam int COORD_W  = 16;
   localparam int SLOT_W   = 6;
   localparam int OP_W     = 2;
   localparam int SQ_W     = 32;   // one squared axis difference
   localparam int DIST_W   = 34;   // sum of three squares
   localparam int LIMIT_W  = 32;   // match radius squared

   localparam int REQ_TDATA_W = 64;
   localparam int REQ_TUSER_W = 2;
   localparam int RSP_TDATA_W = 72;
   localparam int RSP_TUSER_W = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 16;

   // response field positions
   localparam int RSP_SLOT_LSB  = 0;
   localparam int RSP_X_LSB     = 6;
   localparam int RSP_Y_LSB     = 22;
   localparam int RSP_Z_LSB     = 38;
   localparam int RSP_SCORE_LSB = 54;
   localparam int RSP_FULL_BIT  = 0;
   localparam int RSP_FOUND_BIT = 1;

   localparam logic [COORD_W-1:0] NOT_FOUND_SCORE   = 16'hF000;
   localparam logic [COORD_W-1:0] MAX_DIST_RESET    = 16'd410;
   localparam logic [COORD_W-1:0] SCORE_FLOOR_RESET = 16'd0;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_DIST    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SCORE_FLOOR = 1'd1;

   typedef enum logic [OP_W-1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_QUERY  = 2'd2
   } op_type;

   typedef struct packed {
      logic [COORD_W-1:0] score;
      logic [COORD_W-1:0] z;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] x;
   } point_type;

   typedef struct packed {
      logic valid;
      logic last;
      logic qual;
   } cand_ctl_type;

   typedef struct packed {
      logic              table_full;
      logic              found;
      logic [SLOT_W-1:0] slot;
      point_type         pt;
   } result_type;

endpackage

`default_nettype wire

// ===== design/npm_pt_mem.sv =====
// ---------------------------------------------------------------------------
// npm_pt_mem
// Point table: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module npm_pt_mem #(
   parameter int DEPTH  = npm_pkg::MAX_POINTS_DEF,
   parameter int ADDR_W = 6
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire npm_pkg::point_type wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output      npm_pkg::point_type rd_data
);
   import npm_pkg::*;

   point_type store_ff [DEPTH];
   point_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== design/npm_dist.sv =====
// ---------------------------------------------------------------------------
// npm_dist
// Three-stage squared distance pipeline: differences, squares, sum + limit.
// ---------------------------------------------------------------------------
`default_nettype none

module npm_dist #(
   parameter int IDX_W = 6
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         in_valid,
   input  wire logic                         in_last,
   input  wire logic [IDX_W-1:0]             in_idx,
   input  wire npm_pkg::point_type           in_pt,
   input  wire logic [npm_pkg::COORD_W-1:0]  ctr_x,
   input  wire logic [npm_pkg::COORD_W-1:0]  ctr_y,
   input  wire logic [npm_pkg::COORD_W-1:0]  ctr_z,
   input  wire logic [npm_pkg::COORD_W-1:0]  score_floor,
   input  wire logic [npm_pkg::LIMIT_W-1:0]  limit,
   output      npm_pkg::cand_ctl_type        out_ctl,
   output      logic [IDX_W-1:0]             out_idx,
   output      logic [npm_pkg::DIST_W-1:0]   out_dist,
   output      npm_pkg::point_type           out_pt
);
   import npm_pkg::*;

   localparam int SQF_W = 2*COORD_W + 2;

   // stage 1: axis differences, score gate
   logic                      s1_valid_ff, s1_last_ff, s1_ok_ff;
   logic [IDX_W-1:0]          s1_idx_ff;
   point_type                 s1_pt_ff;
   logic signed [COORD_W:0]   dx_ff, dy_ff, dz_ff;
   logic signed [COORD_W:0]   dx_in, dy_in, dz_in;
   logic                      ok_in;

   assign dx_in = $signed({in_pt.x[COORD_W-1], in_pt.x}) - $signed({ctr_x[COORD_W-1], ctr_x});
   assign dy_in = $signed({in_pt.y[COORD_W-1], in_pt.y}) - $signed({ctr_y[COORD_W-1], ctr_y});
   assign dz_in = $signed({in_pt.z[COORD_W-1], in_pt.z}) - $signed({ctr_z[COORD_W-1], ctr_z});
   assign ok_in = $signed(in_pt.score) >= $signed(score_floor);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
      end
      s1_last_ff <= in_last;
      s1_ok_ff   <= ok_in;
      s1_idx_ff  <= in_idx;
      s1_pt_ff   <= in_pt;
      dx_ff      <= dx_in;
      dy_ff      <= dy_in;
      dz_ff      <= dz_in;
   end

   // stage 2: squares; |d| <= 65535 so each square fits 32 bits
   logic                      s2_valid_ff, s2_last_ff, s2_ok_ff;
   logic [IDX_W-1:0]          s2_idx_ff;
   point_type                 s2_pt_ff;
   logic [SQ_W-1:0]           sqx_ff, sqy_ff, sqz_ff;
   logic signed [SQF_W-1:0]   sqx_full, sqy_full, sqz_full;

   assign sqx_full = SQF_W'(dx_ff) * SQF_W'(dx_ff);
   assign sqy_full = SQF_W'(dy_ff) * SQF_W'(dy_ff);
   assign sqz_full = SQF_W'(dz_ff) * SQF_W'(dz_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_last_ff <= s1_last_ff;
      s2_ok_ff   <= s1_ok_ff;
      s2_idx_ff  <= s1_idx_ff;
      s2_pt_ff   <= s1_pt_ff;
      sqx_ff     <= sqx_full[SQ_W-1:0];
      sqy_ff     <= sqy_full[SQ_W-1:0];
      sqz_ff     <= sqz_full[SQ_W-1:0];
   end

   // stage 3: sum and radius test
   cand_ctl_type              s3_ctl_ff;
   logic [IDX_W-1:0]          s3_idx_ff;
   point_type                 s3_pt_ff;
   logic [DIST_W-1:0]         s3_dist_ff;
   logic [DIST_W-1:0]         sum_in;

   assign sum_in = DIST_W'(sqx_ff) + DIST_W'(sqy_ff) + DIST_W'(sqz_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_ctl_ff.valid <= 1'b0;
      end else begin
         s3_ctl_ff.valid <= s2_valid_ff;
      end
      s3_ctl_ff.last <= s2_last_ff;
      s3_ctl_ff.qual <= s2_ok_ff && (sum_in < DIST_W'(limit));
      s3_idx_ff      <= s2_idx_ff;
      s3_pt_ff       <= s2_pt_ff;
      s3_dist_ff     <= sum_in;
   end

   assign out_ctl  = s3_ctl_ff;
   assign out_idx  = s3_idx_ff;
   assign out_dist = s3_dist_ff;
   assign out_pt   = s3_pt_ff;

endmodule

`default_nettype wire

// ===== design/nearest_point_matcher_core.sv =====
// ---------------------------------------------------------------------------
// nearest_point_matcher_core
// Point table with clear, append and fixed-radius nearest point query.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one command beat: tuser is the op, tdata the point or the
//   query center with its score. rsp_* returns exactly one beat per command.
//   csr_* writes the match radius (index 0) and the score floor (index 1);
//   write it only while no command is in flight.
// Response timing and throughput:
//   clear and append: response registered at accept if the response register
//   is free; one command per cycle while the response side keeps up.
//   query over N stored points: no new command is accepted until the query
//   has answered. The table is read one entry per cycle through its single
//   read port and each entry passes a three-stage distance pipeline and a
//   compare stage. A query on an empty table answers like a clear.
// Reset: point count goes to zero and registers take their reset values;
//   table contents are not cleared, only slots below the count are read.
// Stall: the response register holds while rsp_tready is low. One more
//   command is accepted meanwhile; its result is parked and req_tready
//   stays low until the parked result moves out.
// ---------------------------------------------------------------------------
`default_nettype none

module nearest_point_matcher_core #(
   parameter int MAX_POINTS = npm_pkg::MAX_POINTS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // req: tuser = op; tdata = pos_x, pos_y, pos_z, point_score
   input  wire logic                            req_tvalid,
   output      logic                            req_tready,
   input  wire logic [npm_pkg::REQ_TDATA_W-1:0] req_tdata,
   input  wire logic [npm_pkg::REQ_TUSER_W-1:0] req_tuser,
   // rsp: tuser = table_full, found
   //      tdata = slot, match_x, match_y, match_z, match_score, 2 pad bits
   output      logic                            rsp_tvalid,
   input  wire logic                            rsp_tready,
   output      logic [npm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output      logic [npm_pkg::RSP_TUSER_W-1:0] rsp_tuser,
   // csr write channel
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [npm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [npm_pkg::CSR_DATA_W-1:0]  csr_data
);
   import npm_pkg::*;

   localparam int ADDR_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CNT_W  = $clog2(MAX_POINTS + 1);

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_HOLD  = 4'b1000
   } state_type;

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [ADDR_W-1:0]  rd_addr_ff, rd_addr_in;

   logic [COORD_W-1:0] max_dist_ff, score_floor_ff;
   logic [LIMIT_W-1:0] limit_ff;
   logic [COORD_W-1:0] ctr_x_ff, ctr_y_ff, ctr_z_ff;

   logic               iss_valid_ff, iss_last_ff;
   logic [ADDR_W-1:0]  iss_idx_ff;

   logic               have_ff, fin_ff;
   logic [DIST_W-1:0]  best_d_ff;
   logic [ADDR_W-1:0]  best_idx_ff;
   point_type          best_pt_ff;

   result_type         res_ff, res_new, load_val;
   logic               rsp_valid_ff, rsp_valid_in;
   result_type         rsp_res_ff, rsp_res_in;

   logic               req_fire, out_free, tbl_full;
   logic               mem_we, rd_en, scan_last, query_start;
   logic               res_go, load_rsp, hold_wr;
   point_type          in_pt, rd_pt;

   cand_ctl_type       cand_ctl;
   logic [ADDR_W-1:0]  cand_idx;
   logic [DIST_W-1:0]  cand_d;
   point_type          cand_pt;
   logic               better;

   assign in_pt.x     = req_tdata[COORD_W-1:0];
   assign in_pt.y     = req_tdata[2*COORD_W-1:COORD_W];
   assign in_pt.z     = req_tdata[3*COORD_W-1:2*COORD_W];
   assign in_pt.score = req_tdata[4*COORD_W-1:3*COORD_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign tbl_full   = (cnt_ff >= CNT_W'(MAX_POINTS));
   assign csr_ready  = 1'b1;

   // appends land only while idle, scans only read: ports never collide
   npm_pt_mem #(
      .DEPTH  (MAX_POINTS),
      .ADDR_W (ADDR_W)
   ) u_mem (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (ADDR_W'(cnt_ff)),
      .wr_data (in_pt),
      .rd_en   (rd_en),
      .rd_addr (rd_addr_ff),
      .rd_data (rd_pt)
   );

   npm_dist #(
      .IDX_W (ADDR_W)
   ) u_dist (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (iss_valid_ff),
      .in_last     (iss_last_ff),
      .in_idx      (iss_idx_ff),
      .in_pt       (rd_pt),
      .ctr_x       (ctr_x_ff),
      .ctr_y       (ctr_y_ff),
      .ctr_z       (ctr_z_ff),
      .score_floor (score_floor_ff),
      .limit       (limit_ff),
      .out_ctl     (cand_ctl),
      .out_idx     (cand_idx),
      .out_dist    (cand_d),
      .out_pt      (cand_pt)
   );

   // strict compare keeps the lower slot on equal distance
   assign better = cand_ctl.valid && cand_ctl.qual && (!have_ff || (cand_d < best_d_ff));

   always_comb begin
      state_in    = state_ff;
      cnt_in      = cnt_ff;
      rd_addr_in  = rd_addr_ff;
      mem_we      = 1'b0;
      rd_en       = 1'b0;
      scan_last   = 1'b0;
      query_start = 1'b0;
      res_go      = 1'b0;
      load_rsp    = 1'b0;
      hold_wr     = 1'b0;
      load_val    = res_ff;
      res_new          = '0;
      res_new.pt.score = NOT_FOUND_SCORE;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (op_type'(req_tuser[OP_W-1:0]))
                  OP_CLEAR: begin
                     cnt_in = '0;
                     res_go = 1'b1;
                  end
                  OP_APPEND: begin
                     res_go = 1'b1;
                     if (tbl_full) begin
                        res_new.table_full = 1'b1;
                     end else begin
                        mem_we       = 1'b1;
                        cnt_in       = cnt_ff + 1'b1;
                        res_new.slot = SLOT_W'(cnt_ff);
                     end
                  end
                  OP_QUERY: begin
                     if (cnt_ff == '0) begin
                        res_go = 1'b1;
                     end else begin
                        query_start = 1'b1;
                        rd_addr_in  = '0;
                        state_in    = ST_SCAN;
                     end
                  end
                  default: begin
                     res_go = 1'b1;
                  end
               endcase
            end
         end
         ST_SCAN: begin
            rd_en      = 1'b1;
            rd_addr_in = rd_addr_ff + 1'b1;
            scan_last  = (CNT_W'(rd_addr_ff) == (cnt_ff - 1'b1));
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (fin_ff) begin
               res_go = 1'b1;
               if (have_ff) begin
                  res_new.found = 1'b1;
                  res_new.slot  = SLOT_W'(best_idx_ff);
                  res_new.pt    = best_pt_ff;
               end
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               load_rsp = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (res_go) begin
         if (out_free) begin
            load_rsp = 1'b1;
            load_val = res_new;
            state_in = ST_IDLE;
         end else begin
            hold_wr  = 1'b1;
            state_in = ST_HOLD;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_res_in   = rsp_res_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = load_val;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         cnt_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
         iss_valid_ff   <= 1'b0;
         have_ff        <= 1'b0;
         fin_ff         <= 1'b0;
         max_dist_ff    <= MAX_DIST_RESET;
         score_floor_ff <= SCORE_FLOOR_RESET;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         iss_valid_ff <= rd_en;
         fin_ff       <= cand_ctl.valid && cand_ctl.last;
         if (query_start) begin
            have_ff <= 1'b0;
         end else if (better) begin
            have_ff <= 1'b1;
         end
         if (csr_valid) begin
            case (csr_index)
               CSR_MAX_DIST:    max_dist_ff    <= csr_data;
               CSR_SCORE_FLOOR: score_floor_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_addr_ff  <= rd_addr_in;
      iss_last_ff <= scan_last;
      iss_idx_ff  <= rd_addr_ff;
      rsp_res_ff  <= rsp_res_in;
      if (hold_wr) begin
         res_ff <= res_new;
      end
      if (query_start) begin
         limit_ff <= LIMIT_W'(max_dist_ff) * LIMIT_W'(max_dist_ff);
         ctr_x_ff <= in_pt.x;
         ctr_y_ff <= in_pt.y;
         ctr_z_ff <= in_pt.z;
      end
      if (better) begin
         best_d_ff   <= cand_d;
         best_idx_ff <= cand_idx;
         best_pt_ff  <= cand_pt;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = {rsp_res_ff.found, rsp_res_ff.table_full};
   assign rsp_tdata  = {2'b00, rsp_res_ff.pt.score, rsp_res_ff.pt.z, rsp_res_ff.pt.y,
                        rsp_res_ff.pt.x, rsp_res_ff.slot};

endmodule

`default_nettype wire

// ===== design/npm_checker.sv =====
// ---------------------------------------------------------------------------
// npm_checker
// Port-level checks on the response channel, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "nearest_point_matcher_core_defines.svh"

module npm_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [npm_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input wire logic [npm_pkg::RSP_TUSER_W-1:0] rsp_tuser
);
   import npm_pkg::*;

   logic               found, full;
   logic [SLOT_W-1:0]  slot;
   logic [COORD_W-1:0] mx, my, mz, msc;
   logic               rsp_stall, miss_clean;
   logic [RSP_TUSER_W+RSP_TDATA_W-1:0] rsp_beat;

   assign full  = rsp_tuser[RSP_FULL_BIT];
   assign found = rsp_tuser[RSP_FOUND_BIT];
   assign slot  = rsp_tdata[RSP_SLOT_LSB +: SLOT_W];
   assign mx    = rsp_tdata[RSP_X_LSB +: COORD_W];
   assign my    = rsp_tdata[RSP_Y_LSB +: COORD_W];
   assign mz    = rsp_tdata[RSP_Z_LSB +: COORD_W];
   assign msc   = rsp_tdata[RSP_SCORE_LSB +: COORD_W];

   assign rsp_stall  = rsp_tvalid && !rsp_tready;
   assign rsp_beat   = {rsp_tuser, rsp_tdata};
   assign miss_clean = (mx == '0) && (my == '0) && (mz == '0) && (msc == NOT_FOUND_SCORE);

   `NPM_ASSERT_ALWAYS(a_rst_quiet, clock, reset |=> !rsp_tvalid, "rsp valid after reset")

   `NPM_ASSERT(a_rsp_hold, clock, reset, rsp_stall |=> rsp_tvalid && $stable(rsp_beat), "stalled beat changed")

   `NPM_ASSERT(a_miss_fields, clock, reset, rsp_tvalid && !found |-> miss_clean, "miss beat carries match data")

   `NPM_ASSERT(a_full_excl, clock, reset, rsp_tvalid && full |-> !found && slot == '0, "refused append reports a slot")

endmodule

bind nearest_point_matcher_core npm_checker u_npm_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top: nearest_point_matcher_core regression
// Drives clear/append/query commands over the req stream, writes the radius
// and score threshold between phases, and checks every rsp beat in order and
// field by field against an in-bench point table model or a typed expectation.
// ---------------------------------------------------------------------------
module tb_top;
   import npm_pkg::*;

   typedef struct packed {
      bit        full;
      bit        found;
      bit [5:0]  slot;
      bit [15:0] mx;
      bit [15:0] my;
      bit [15:0] mz;
      bit [15:0] ms;
   } match_type;

   typedef struct {
      op_type    op;
      bit [15:0] x;
      bit [15:0] y;
      bit [15:0] z;
      bit [15:0] s;
      int        reps;
      bit        typed;
      match_type res;
   } dir_row_type;

   localparam match_type MISS = '{1'b0, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0, NOT_FOUND_SCORE};
   localparam int        HOLD_CYCLES = 300;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic [REQ_TUSER_W-1:0] req_tuser = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic [RSP_TUSER_W-1:0] rsp_tuser;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // typed expectation that travels with a directed beat
   logic                   dir_expect_en = 1'b0;
   match_type              dir_expect = MISS;
   logic                   hold_go = 1'b0;

   // predictor state
   bit [15:0] tbl_x [MAX_POINTS_DEF];
   bit [15:0] tbl_y [MAX_POINTS_DEF];
   bit [15:0] tbl_z [MAX_POINTS_DEF];
   bit [15:0] tbl_s [MAX_POINTS_DEF];
   int        tbl_count = 0;
   bit [15:0] cfg_radius = MAX_DIST_RESET;
   bit [15:0] cfg_score_floor = SCORE_FLOOR_RESET;

   match_type expected_matches [$];
   match_type got_match;
   match_type want_match;
   match_type calc_match;
   int        fails = 0;

   // sender's own view of the table, used to aim queries
   bit [15:0] pts_x [MAX_POINTS_DEF];
   bit [15:0] pts_y [MAX_POINTS_DEF];
   bit [15:0] pts_z [MAX_POINTS_DEF];
   int        pts_n = 0;
   int        burst_left = 0;
   int        issued = 0;

   nearest_point_matcher_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // pos_x, pos_y, pos_z, point_score
      .req_tuser  (req_tuser),   // op
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // slot, match_x, match_y, match_z, match_score, pad
      .rsp_tuser  (rsp_tuser),   // table_full, found
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------
   function automatic match_type match_step(logic [1:0] code, logic [63:0] data);
      match_type res;
      bit [15:0] cx;
      bit [15:0] cy;
      bit [15:0] cz;
      longint    lim;
      longint    d;
      longint    best_d;
      longint    dx;
      longint    dy;
      longint    dz;
      int        best;
      bit        have;
      res = MISS;
      cx  = data[15:0];
      cy  = data[31:16];
      cz  = data[47:32];
      case (op_type'(code))
         OP_CLEAR: tbl_count = 0;
         OP_APPEND: begin
            if (tbl_count >= MAX_POINTS_DEF) begin
               res.full = 1'b1;
            end else begin
               tbl_x[tbl_count] = cx;
               tbl_y[tbl_count] = cy;
               tbl_z[tbl_count] = cz;
               tbl_s[tbl_count] = data[63:48];
               res.slot = 6'(tbl_count);
               tbl_count++;
            end
         end
         OP_QUERY: begin
            lim    = longint'(cfg_radius) * longint'(cfg_radius);
            have   = 1'b0;
            best   = 0;
            best_d = 0;
            for (int i = 0; i < tbl_count; i++) begin
               if ($signed(tbl_s[i]) < $signed(cfg_score_floor)) continue;
               dx = longint'($signed(tbl_x[i])) - longint'($signed(cx));
               dy = longint'($signed(tbl_y[i])) - longint'($signed(cy));
               dz = longint'($signed(tbl_z[i])) - longint'($signed(cz));
               d  = dx * dx + dy * dy + dz * dz;
               // strict compare keeps the lower slot on ties
               if (d < lim && (!have || d < best_d)) begin
                  have   = 1'b1;
                  best_d = d;
                  best   = i;
               end
            end
            if (have) begin
               res.found = 1'b1;
               res.slot  = 6'(best);
               res.mx    = tbl_x[best];
               res.my    = tbl_y[best];
               res.mz    = tbl_z[best];
               res.ms    = tbl_s[best];
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fails++;
      end
   endtask

   // response checking, then prediction of newly accepted beats
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got_match.full  = rsp_tuser[RSP_FULL_BIT];
            got_match.found = rsp_tuser[RSP_FOUND_BIT];
            got_match.slot  = rsp_tdata[RSP_SLOT_LSB +: SLOT_W];
            got_match.mx    = rsp_tdata[RSP_X_LSB +: COORD_W];
            got_match.my    = rsp_tdata[RSP_Y_LSB +: COORD_W];
            got_match.mz    = rsp_tdata[RSP_Z_LSB +: COORD_W];
            got_match.ms    = rsp_tdata[RSP_SCORE_LSB +: COORD_W];
            if (expected_matches.size() == 0) begin
               $error("rsp beat with nothing expected: tuser %0h tdata %0h", rsp_tuser,
                      rsp_tdata);
               fails++;
            end else begin
               want_match = expected_matches.pop_front();
               check_field("table_full", 16'(want_match.full), 16'(got_match.full));
               check_field("found", 16'(want_match.found), 16'(got_match.found));
               check_field("slot", 16'(want_match.slot), 16'(got_match.slot));
               check_field("match_x", want_match.mx, got_match.mx);
               check_field("match_y", want_match.my, got_match.my);
               check_field("match_z", want_match.mz, got_match.mz);
               check_field("match_score", want_match.ms, got_match.ms);
            end
         end
         if (req_tvalid && req_tready) begin
            calc_match = match_step(req_tuser, req_tdata);
            expected_matches.insert(expected_matches.size(),
                                    dir_expect_en ? dir_expect : calc_match);
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_MAX_DIST) cfg_radius = csr_data;
            else cfg_score_floor = csr_data;
         end
      end
   end

   // ------------------------------------------------------------------------
   // receiver: stall pattern plus one long hold-off
   // ------------------------------------------------------------------------
   initial begin
      int rx_cyc;
      int rx_mode;
      int hold_cnt;
      bit hold_done;
      rx_cyc    = 0;
      rx_mode   = 0;
      hold_cnt  = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         rx_cyc++;
         if (hold_go && !hold_done) begin
            rsp_tready <= 1'b0;
            hold_cnt++;
            if (hold_cnt == HOLD_CYCLES) hold_done = 1'b1;
         end else begin
            if (rx_cyc % 64 == 0) rx_mode = $urandom_range(0, 3);
            case (rx_mode)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= rx_cyc[2];
               default: rsp_tready <= 1'($urandom_range(0, 1));
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // sender
   // ------------------------------------------------------------------------
   task automatic pace();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 16);
         gap        = $urandom_range(1, 10);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic issue(op_type op, bit [15:0] x, bit [15:0] y, bit [15:0] z,
                        bit [15:0] s, bit typed, match_type res);
      req_tvalid    <= 1'b1;
      req_tuser     <= op;
      req_tdata     <= {s, z, y, x};
      dir_expect_en <= typed;
      dir_expect    <= res;
      do @(posedge clock); while (!req_tready);
      if (op == OP_CLEAR) begin
         pts_n = 0;
      end else if (op == OP_APPEND && pts_n < MAX_POINTS_DEF) begin
         pts_x[pts_n] = x;
         pts_y[pts_n] = y;
         pts_z[pts_n] = z;
         pts_n++;
      end
      issued++;
      pace();
   endtask

   // wait out every outstanding beat, then the query pipeline
   task automatic settle();
      if (req_tvalid) req_tvalid <= 1'b0;
      // wait so the predictor has queued the last accepted beat
      @(posedge clock);
      while (expected_matches.size() != 0) @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, bit [15:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic set_config(bit [15:0] radius, bit [15:0] min_sc);
      settle();
      write_reg(CSR_MAX_DIST, radius);
      write_reg(CSR_SCORE_FLOOR, min_sc);
      csr_valid <= 1'b0;
   endtask

   function automatic bit [15:0] clamp16(int v);
      if (v > 32767) return 16'h7FFF;
      if (v < -32768) return 16'h8000;
      return 16'(v);
   endfunction

   function automatic bit [15:0] rand_coord();
      if ($urandom_range(0, 1) == 0) return 16'($urandom_range(0, 2047) - 1024);
      return 16'($urandom);
   endfunction

   function automatic bit [15:0] rand_score(bit [15:0] min_sc);
      case ($urandom_range(0, 3))
         0: return min_sc;
         1: return min_sc + 16'(($urandom_range(0, 1) == 0) ? 1 : -1);
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic run_phase(int n_items, bit [15:0] radius, bit [15:0] min_sc);
      int        stop_at;
      int        k;
      int        m;
      int        j;
      int        r;
      bit [15:0] qx;
      bit [15:0] qy;
      bit [15:0] qz;
      stop_at = issued + n_items;
      while (issued < stop_at) begin
         if ($urandom_range(0, 9) < 8) begin
            if ($urandom_range(0, 3) != 0) issue(OP_CLEAR, rand_coord(), rand_coord(),
                                                 rand_coord(), 16'($urandom), 1'b0, MISS);
            k = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 12);
            repeat (k) begin
               if (pts_n > 0 && $urandom_range(0, 5) == 0) begin
                  // duplicate position for tie-breaking
                  j = $urandom_range(0, pts_n - 1);
                  issue(OP_APPEND, pts_x[j], pts_y[j], pts_z[j], rand_score(min_sc),
                        1'b0, MISS);
               end else begin
                  issue(OP_APPEND, rand_coord(), rand_coord(), rand_coord(),
                        rand_score(min_sc), 1'b0, MISS);
               end
            end
            m = $urandom_range(1, 6);
            repeat (m) begin
               j = (pts_n > 0) ? $urandom_range(0, pts_n - 1) : 0;
               r = radius;
               case ($urandom_range(0, 19))
                  0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
                     if (pts_n > 0) begin
                        qx = clamp16($signed(pts_x[j]) + int'($urandom_range(0, r)) - r / 2);
                        qy = clamp16($signed(pts_y[j]) + int'($urandom_range(0, r)) - r / 2);
                        qz = clamp16($signed(pts_z[j]) + int'($urandom_range(0, r)) - r / 2);
                     end else begin
                        qx = rand_coord();
                        qy = rand_coord();
                        qz = rand_coord();
                     end
                  end
                  12, 13, 14: begin
                     qx = (pts_n > 0) ? pts_x[j] : 16'd0;
                     qy = (pts_n > 0) ? pts_y[j] : 16'd0;
                     qz = (pts_n > 0) ? pts_z[j] : 16'd0;
                  end
                  default: begin
                     qx = rand_coord();
                     qy = rand_coord();
                     qz = rand_coord();
                  end
               endcase
               issue(OP_QUERY, qx, qy, qz, 16'($urandom), 1'b0, MISS);
            end
            if ($urandom_range(0, 29) == 0) settle();
         end else begin
            // any op code, the unused one included
            issue(op_type'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom), 1'b0, MISS);
         end
      end
   endtask

   dir_row_type dir_table [21] = '{
      // empty table right after reset
      '{OP_QUERY,  16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1'b1, MISS},
      '{OP_APPEND, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1, 1'b1, MISS},
      '{OP_APPEND, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1, 1'b1,
        '{1'b0, 1'b0, 6'd1, 16'd0, 16'd0, 16'd0, NOT_FOUND_SCORE}},
      '{OP_QUERY,  16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h0000, 1, 1'b1,
        '{1'b0, 1'b1, 6'd0, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}},
      // point exists but its score is below the threshold
      '{OP_QUERY,  16'h8000, 16'h8000, 16'h8000, 16'h0000, 1, 1'b1, MISS},
      '{OP_APPEND, 16'd100,  16'd200,  16'd300,  16'd0,    1, 1'b1,
        '{1'b0, 1'b0, 6'd2, 16'd0, 16'd0, 16'd0, NOT_FOUND_SCORE}},
      '{OP_APPEND, 16'd100,  16'd200,  16'd300,  16'd4096, 1, 1'b1,
        '{1'b0, 1'b0, 6'd3, 16'd0, 16'd0, 16'd0, NOT_FOUND_SCORE}},
      // equal distance: lower slot wins
      '{OP_QUERY,  16'd100,  16'd200,  16'd300,  16'h0000, 1, 1'b1,
        '{1'b0, 1'b1, 6'd2, 16'd100, 16'd200, 16'd300, 16'd0}},
      // just inside and exactly on the radius
      '{OP_QUERY,  16'd509,  16'd200,  16'd300,  16'h0000, 1, 1'b0, MISS},
      '{OP_QUERY,  16'd510,  16'd200,  16'd300,  16'h0000, 1, 1'b0, MISS},
      '{OP_QUERY,  16'd100,  16'hFF92, 16'd300,  16'h0000, 1, 1'b0, MISS},
      '{OP_APPEND, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1, 1'b0, MISS},
      '{OP_APPEND, 16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 1, 1'b0, MISS},
      '{OP_QUERY,  16'h5555, 16'hAAAA, 16'h5555, 16'hFFFF, 1, 1'b0, MISS},
      '{OP_QUERY,  16'hAAAA, 16'h5555, 16'hAAAA, 16'hFFFF, 1, 1'b0, MISS},
      // fill the remaining slots, then one append too many
      '{OP_APPEND, 16'h0100, 16'h0200, 16'hFF00, 16'h0800, 58, 1'b0, MISS},
      '{OP_APPEND, 16'h0123, 16'h0456, 16'h0789, 16'h0100, 1, 1'b1,
        '{1'b1, 1'b0, 6'd0, 16'd0, 16'd0, 16'd0, NOT_FOUND_SCORE}},
      '{OP_QUERY,  16'h0272, 16'h0200, 16'hFF00, 16'h0000, 1, 1'b0, MISS},
      '{OP_CLEAR,  16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 1'b1, MISS},
      '{OP_QUERY,  16'h0272, 16'h0200, 16'hFF00, 16'h0000, 1, 1'b1, MISS},
      '{OP_APPEND, 16'h1234, 16'h0000, 16'h0000, 16'h0001, 1, 1'b1, MISS}
   };

   initial begin
      bit [15:0] radius;
      bit [15:0] min_sc;
      int        n_items;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_table[i]) begin
         for (int r = 0; r < dir_table[i].reps; r++) begin
            issue(dir_table[i].op, dir_table[i].x + 16'(r * 37), dir_table[i].y,
                  dir_table[i].z, dir_table[i].s,
                  dir_table[i].typed && dir_table[i].reps == 1, dir_table[i].res);
         end
      end

      for (int ph = 0; ph < 8; ph++) begin
         n_items = 130;
         case (ph)
            0: begin radius = 16'd410;   min_sc = 16'h0000; n_items = 150; end
            1: begin radius = 16'd0;     min_sc = 16'h8000; n_items = 100; end
            2: begin radius = 16'hFFFF;  min_sc = 16'h8000; n_items = 150; end
            3: begin radius = 16'hFFFF;  min_sc = 16'h7FFF; n_items = 120; end
            4: begin radius = 16'd1000;  min_sc = 16'hF000; n_items = 150; end
            default: begin
               radius = 16'($urandom_range(0, 65535));
               min_sc = 16'($urandom);
            end
         endcase
         set_config(radius, min_sc);
         // receiver holds off while appends keep coming
         if (ph == 0) hold_go <= 1'b1;
         run_phase(n_items, radius, min_sc);
      end

      settle();
      if (fails == 0 && expected_matches.size() == 0) begin
         $display("nearest_point_matcher_core regression: pass");
      end else begin
         if (expected_matches.size() != 0)
            $error("%0d expected rsp beats never arrived", expected_matches.size());
         $display("nearest_point_matcher_core regression: fail");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("nearest_point_matcher_core regression: fail");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+design
design/npm_pkg.sv
design/npm_pt_mem.sv
design/npm_dist.sv
design/nearest_point_matcher_core.sv
design/npm_checker.sv
sim/tb_top.sv
